// File: sv/rdat_pkg.sv
// ----------------------------------------------------------------------------
// rdat_pkg
// Shared types and constants of the reliable datagram ack tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rdat_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int HANDLE_BITS_DEF   = 16;

  localparam int SEQ_W     = 16;
  localparam int TIME_W    = 32;
  localparam int MASK_W    = 32;
  localparam int TIMEOUT_W = 16;
  localparam int ACTION_W  = 2;
  localparam int KIND_W    = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd200;

  // action codes of an input item
  typedef enum logic [ACTION_W-1:0] {
    ACT_SEND = 2'd0,
    ACT_RECV = 2'd1,
    ACT_SCAN = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // kind codes of a result item
  typedef enum logic [KIND_W-1:0] {
    KIND_SEND     = 2'd0,
    KIND_RECV     = 2'd1,
    KIND_RETX     = 2'd2,
    KIND_SCAN_END = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_WRITE,
    ST_RECV,
    ST_SCAN,
    ST_DONE
  } state_t;

  // one table entry without its handle
  typedef struct packed {
    logic              occ;
    logic              acked;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] stamp;
  } entry_meta_t;

endpackage

`default_nettype wire

// File: sv/rdat_cell.sv
// ----------------------------------------------------------------------------
// rdat_cell
// One slot of the rotating retransmit table, passed to its neighbor on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rdat_cell
  import rdat_pkg::*;
#(
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   shift_en,
  input  wire entry_meta_t            d_meta,
  input  wire logic [HANDLE_BITS-1:0] d_handle,
  output entry_meta_t                 q_meta,
  output logic [HANDLE_BITS-1:0]      q_handle
);

  logic                   occ_r;
  logic                   acked_r;
  logic [SEQ_W-1:0]       seq_r;
  logic [TIME_W-1:0]      stamp_r;
  logic [HANDLE_BITS-1:0] handle_r;

  // status bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= 1'b0;
      acked_r <= 1'b0;
    end else if (shift_en) begin
      occ_r   <= d_meta.occ;
      acked_r <= d_meta.acked;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (shift_en) begin
      seq_r    <= d_meta.seq;
      stamp_r  <= d_meta.stamp;
      handle_r <= d_handle;
    end
  end

  assign q_meta.occ   = occ_r;
  assign q_meta.acked = acked_r;
  assign q_meta.seq   = seq_r;
  assign q_meta.stamp = stamp_r;
  assign q_handle     = handle_r;

endmodule

`default_nettype wire

// File: sv/rdat_ctrl.sv
// ----------------------------------------------------------------------------
// rdat_ctrl
// Sequencer: header state, one pass of the ring per table walk, result item.
// ----------------------------------------------------------------------------
`default_nettype none

module rdat_ctrl
  import rdat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int HANDLE_BITS   = HANDLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input item
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [ACTION_W-1:0]    in_action,
  input  wire logic                   in_reliable,
  input  wire logic [HANDLE_BITS-1:0] in_handle,
  input  wire logic [SEQ_W-1:0]       in_rx_seq,
  input  wire logic [SEQ_W-1:0]       in_rx_ack,
  input  wire logic [MASK_W-1:0]      in_rx_mask,
  input  wire logic [TIME_W-1:0]      in_now,
  // configuration
  input  wire logic                   cfg_we,
  input  wire logic [TIMEOUT_W-1:0]   cfg_data,
  // result item
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [KIND_W-1:0]           out_kind,
  output logic [SEQ_W-1:0]            out_seq,
  output logic [SEQ_W-1:0]            out_ack,
  output logic [MASK_W-1:0]           out_mask,
  output logic [HANDLE_BITS-1:0]      out_handle,
  output logic                        out_queued,
  output logic                        out_dropped,
  output logic                        out_last,
  // ring
  input  wire entry_meta_t            head_meta,
  input  wire logic [HANDLE_BITS-1:0] head_handle,
  output entry_meta_t                 wb_meta,
  output logic [HANDLE_BITS-1:0]      wb_handle,
  output logic                        shift_en
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam int CLM_N = MASK_W + 1;
  localparam int CLM_W = $clog2(CLM_N);

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       pos_r, pos_nxt;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic [IDX_W-1:0]       tgt_r, tgt_nxt;
  logic                   fnd_any_r, fnd_any_nxt;
  logic                   fnd_hi_r, fnd_hi_nxt;
  logic [CLM_N-1:0]       clm_r, clm_nxt;
  logic [SEQ_W-1:0]       lseq_r, lseq_nxt;
  logic [SEQ_W-1:0]       rseq_r, rseq_nxt;
  logic [MASK_W-1:0]      amask_r, amask_nxt;
  logic [TIMEOUT_W-1:0]   tmo_r;

  // latched input item
  logic [ACTION_W-1:0]    act_r;
  logic                   rel_r;
  logic [HANDLE_BITS-1:0] hdl_r;
  logic [SEQ_W-1:0]       rs_r;
  logic [SEQ_W-1:0]       ra_r;
  logic [MASK_W-1:0]      rm_r;
  logic [TIME_W-1:0]      now_r;

  // output register
  logic                   ov_r, ov_nxt;
  logic [KIND_W-1:0]      ok_r, ok_nxt;
  logic [SEQ_W-1:0]       os_r, os_nxt;
  logic [SEQ_W-1:0]       oa_r, oa_nxt;
  logic [MASK_W-1:0]      om_r, om_nxt;
  logic [HANDLE_BITS-1:0] oh_r, oh_nxt;
  logic                   oq_r, oq_nxt;
  logic                   od_r, od_nxt;
  logic                   ol_r, ol_nxt;

  logic                   slot_free;
  logic                   live;
  logic                   free_here;
  logic                   pass_end;
  logic [TIME_W-1:0]      age;
  logic                   due;
  logic [SEQ_W-1:0]       ack_d;
  logic                   ack_win;
  logic [CLM_W-1:0]       ack_di;
  logic                   ack_bit;
  logic                   ack_hit;
  logic [SEQ_W-1:0]       dnew;
  logic [SEQ_W-1:0]       dold;
  logic                   newer;

  assign slot_free = !ov_r || out_ready;
  assign live      = head_meta.occ && !head_meta.acked;
  assign free_here = !head_meta.occ || head_meta.acked;
  assign pass_end  = (pos_r == IDX_LAST);

  // scan due check, modular age
  assign age = now_r - head_meta.stamp;
  assign due = age >= TIME_W'(tmo_r);

  // ack match: distance back from the received ack
  assign ack_d   = ra_r - head_meta.seq;
  assign ack_win = ack_d <= SEQ_W'(MASK_W);
  assign ack_di  = ack_d[CLM_W-1:0];
  assign ack_bit = (ack_d == '0) ||
                   (ack_win && rm_r[5'(ack_di - CLM_W'(1))]);
  assign ack_hit = live && ack_win && ack_bit && !clm_r[ack_di];

  // wraparound sequence compare against the remote sequence
  assign dnew  = rs_r - rseq_r;
  assign dold  = rseq_r - rs_r;
  assign newer = (dnew != '0) &&
                 ((dnew < 16'h8000) || ((dnew == 16'h8000) && (rs_r > rseq_r)));

  // next state and ring control
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    head_nxt    = head_r;
    tgt_nxt     = tgt_r;
    fnd_any_nxt = fnd_any_r;
    fnd_hi_nxt  = fnd_hi_r;
    clm_nxt     = clm_r;
    lseq_nxt    = lseq_r;
    rseq_nxt    = rseq_r;
    amask_nxt   = amask_r;
    ov_nxt      = ov_r && !out_ready;
    ok_nxt      = ok_r;
    os_nxt      = os_r;
    oa_nxt      = oa_r;
    om_nxt      = om_r;
    oh_nxt      = oh_r;
    oq_nxt      = oq_r;
    od_nxt      = od_r;
    ol_nxt      = ol_r;
    in_ready    = 1'b0;
    shift_en    = 1'b0;
    wb_meta     = head_meta;
    wb_handle   = head_handle;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pos_nxt     = '0;
          fnd_any_nxt = 1'b0;
          fnd_hi_nxt  = 1'b0;
          clm_nxt     = '0;
          case (in_action)
            ACT_SEND: state_nxt = in_reliable ? ST_FIND : ST_DONE;
            ACT_RECV: state_nxt = ST_RECV;
            ACT_SCAN: state_nxt = ST_SCAN;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end

      // look for a free slot, preferring the first at or after the head
      ST_FIND: begin
        shift_en = 1'b1;
        if (free_here) begin
          fnd_any_nxt = 1'b1;
          if (!fnd_any_r) begin
            tgt_nxt = pos_r;
          end
          if ((pos_r >= head_r) && !fnd_hi_r) begin
            fnd_hi_nxt = 1'b1;
            tgt_nxt    = pos_r;
          end
        end
        pos_nxt = pos_r + IDX_W'(1);
        if (pass_end) begin
          pos_nxt   = '0;
          state_nxt = (fnd_any_r || free_here) ? ST_WRITE : ST_DONE;
        end
      end

      // write the new entry as it passes the head
      ST_WRITE: begin
        shift_en = 1'b1;
        if (pos_r == tgt_r) begin
          wb_meta.occ   = 1'b1;
          wb_meta.acked = 1'b0;
          wb_meta.seq   = lseq_r;
          wb_meta.stamp = now_r;
          wb_handle     = hdl_r;
          head_nxt      = (tgt_r == IDX_LAST) ? '0 : tgt_r + IDX_W'(1);
        end
        pos_nxt = pos_r + IDX_W'(1);
        if (pass_end) begin
          pos_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end

      // acknowledge the first live entry for each acked sequence
      ST_RECV: begin
        shift_en = 1'b1;
        if (ack_hit) begin
          wb_meta.acked   = 1'b1;
          clm_nxt[ack_di] = 1'b1;
        end
        pos_nxt = pos_r + IDX_W'(1);
        if (pass_end) begin
          pos_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end

      // emit due entries, holding the ring while the output is full
      ST_SCAN: begin
        if (live && due) begin
          if (slot_free) begin
            shift_en      = 1'b1;
            wb_meta.stamp = now_r;
            ov_nxt        = 1'b1;
            ok_nxt        = KIND_RETX;
            os_nxt        = head_meta.seq;
            oa_nxt        = '0;
            om_nxt        = '0;
            oh_nxt        = head_handle;
            oq_nxt        = 1'b0;
            od_nxt        = 1'b0;
            ol_nxt        = 1'b0;
          end
        end else begin
          shift_en = 1'b1;
        end
        if (shift_en) begin
          pos_nxt = pos_r + IDX_W'(1);
          if (pass_end) begin
            pos_nxt   = '0;
            state_nxt = ST_DONE;
          end
        end
      end

      // final result item of the input item
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
          ov_nxt    = 1'b1;
          ol_nxt    = 1'b1;
          os_nxt    = '0;
          oa_nxt    = '0;
          om_nxt    = '0;
          oh_nxt    = '0;
          oq_nxt    = 1'b0;
          od_nxt    = 1'b0;
          case (act_r)
            ACT_SEND: begin
              ok_nxt   = KIND_SEND;
              os_nxt   = lseq_r;
              oa_nxt   = rseq_r;
              om_nxt   = amask_r;
              oq_nxt   = fnd_any_r;
              od_nxt   = rel_r && !fnd_any_r;
              lseq_nxt = lseq_r + SEQ_W'(1);
            end
            ACT_RECV: begin
              ok_nxt = KIND_RECV;
              if (newer) begin
                rseq_nxt = rs_r;
                if (dnew <= SEQ_W'(MASK_W)) begin
                  amask_nxt = (amask_r << dnew[5:0]) |
                              (MASK_W'(1) << 5'(dnew[5:0] - 6'd1));
                end else begin
                  amask_nxt = '0;
                end
              end else if ((dold != '0) && (dold <= SEQ_W'(MASK_W))) begin
                amask_nxt = amask_r | (MASK_W'(1) << 5'(dold[5:0] - 6'd1));
              end
            end
            default: ok_nxt = KIND_SCAN_END;
          endcase
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      head_r    <= '0;
      fnd_any_r <= 1'b0;
      fnd_hi_r  <= 1'b0;
      clm_r     <= '0;
      lseq_r    <= '0;
      rseq_r    <= '0;
      amask_r   <= '0;
      ov_r      <= 1'b0;
      tmo_r     <= TIMEOUT_RST;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      head_r    <= head_nxt;
      fnd_any_r <= fnd_any_nxt;
      fnd_hi_r  <= fnd_hi_nxt;
      clm_r     <= clm_nxt;
      lseq_r    <= lseq_nxt;
      rseq_r    <= rseq_nxt;
      amask_r   <= amask_nxt;
      ov_r      <= ov_nxt;
      if (cfg_we) begin
        tmo_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tgt_r <= tgt_nxt;
    ok_r  <= ok_nxt;
    os_r  <= os_nxt;
    oa_r  <= oa_nxt;
    om_r  <= om_nxt;
    oh_r  <= oh_nxt;
    oq_r  <= oq_nxt;
    od_r  <= od_nxt;
    ol_r  <= ol_nxt;
    if (in_ready && in_valid) begin
      act_r <= in_action;
      rel_r <= in_reliable;
      hdl_r <= in_handle;
      rs_r  <= in_rx_seq;
      ra_r  <= in_rx_ack;
      rm_r  <= in_rx_mask;
      now_r <= in_now;
    end
  end

  assign out_valid   = ov_r;
  assign out_kind    = ok_r;
  assign out_seq     = os_r;
  assign out_ack     = oa_r;
  assign out_mask    = om_r;
  assign out_handle  = oh_r;
  assign out_queued  = oq_r;
  assign out_dropped = od_r;
  assign out_last    = ol_r;

endmodule

`default_nettype wire

// File: sv/reliable_datagram_ack_tracker.sv
// ----------------------------------------------------------------------------
// reliable_datagram_ack_tracker
// Ack bookkeeping and retransmit table for reliable datagrams.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per action (tuser = action; tdata = reliable, handle,
//           rx_seq, rx_ack, rx_ack_mask, now_ms). in_tready is high only
//           while the block is idle; one item is worked at a time.
//   out_* : result items (tuser = kind), tlast on the final one of an item.
//   cfg_* : write of the retransmit timeout; the user must make it only
//           while the block is idle; the block itself does not enforce it.
// The table is a ring of TABLE_ENTRIES cells that rotates one slot a cycle
// past the controller while a walk runs and no scan is held by a full
// output register; every table walk is one full turn of the ring.
// From accept to the final result item, a reliable send takes one turn to
// pick the slot and one to write it, or only the first when the table is
// full; receive and scan take one turn, and an unreliable send none. An
// unused action is taken and gives no result.
// Reset empties the table, clears the sequences and the ack mask and sets
// the timeout to 200 ms; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module reliable_datagram_ack_tracker
  import rdat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int HANDLE_BITS   = HANDLE_BITS_DEF,
  localparam int IN_BITS  = 1 + HANDLE_BITS + 2 * SEQ_W + MASK_W + TIME_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * SEQ_W + MASK_W + HANDLE_BITS + 2,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // reliable, payload_handle, rx_seq, rx_ack, rx_ack_mask, now_ms
  input  wire logic [IN_W-1:0]      in_tdata,
  // action
  input  wire logic [ACTION_W-1:0]  in_tuser,
  input  wire logic                 cfg_wr_en,
  input  wire logic [TIMEOUT_W-1:0] cfg_wr_data,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // seq_out, ack_out, ack_mask_out, handle_out, queued, dropped
  output logic [OUT_W-1:0]          out_tdata,
  // kind
  output logic [KIND_W-1:0]         out_tuser,
  output logic                      out_tlast
);

  localparam int H_LO = 1;
  localparam int S_LO = H_LO + HANDLE_BITS;
  localparam int A_LO = S_LO + SEQ_W;
  localparam int M_LO = A_LO + SEQ_W;
  localparam int T_LO = M_LO + MASK_W;

  entry_meta_t            meta_q [TABLE_ENTRIES];
  logic [HANDLE_BITS-1:0] hdl_q  [TABLE_ENTRIES];
  entry_meta_t            wb_meta;
  logic [HANDLE_BITS-1:0] wb_handle;
  logic                   shift_en;

  logic [SEQ_W-1:0]       o_seq;
  logic [SEQ_W-1:0]       o_ack;
  logic [MASK_W-1:0]      o_mask;
  logic [HANDLE_BITS-1:0] o_handle;
  logic                   o_queued;
  logic                   o_dropped;

  // controller
  rdat_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .HANDLE_BITS   (HANDLE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_action   (in_tuser),
    .in_reliable (in_tdata[0]),
    .in_handle   (in_tdata[S_LO-1:H_LO]),
    .in_rx_seq   (in_tdata[A_LO-1:S_LO]),
    .in_rx_ack   (in_tdata[M_LO-1:A_LO]),
    .in_rx_mask  (in_tdata[T_LO-1:M_LO]),
    .in_now      (in_tdata[T_LO+TIME_W-1:T_LO]),
    .cfg_we      (cfg_wr_en),
    .cfg_data    (cfg_wr_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_tuser),
    .out_seq     (o_seq),
    .out_ack     (o_ack),
    .out_mask    (o_mask),
    .out_handle  (o_handle),
    .out_queued  (o_queued),
    .out_dropped (o_dropped),
    .out_last    (out_tlast),
    .head_meta   (meta_q[0]),
    .head_handle (hdl_q[0]),
    .wb_meta     (wb_meta),
    .wb_handle   (wb_handle),
    .shift_en    (shift_en)
  );

  // ring of table cells, the controller closes the loop at cell 0
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    if (k == TABLE_ENTRIES - 1) begin : g_tail
      rdat_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_meta   (wb_meta),
        .d_handle (wb_handle),
        .q_meta   (meta_q[k]),
        .q_handle (hdl_q[k])
      );
    end else begin : g_body
      rdat_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_meta   (meta_q[k+1]),
        .d_handle (hdl_q[k+1]),
        .q_meta   (meta_q[k]),
        .q_handle (hdl_q[k])
      );
    end
  end

  // result payload packing
  assign out_tdata = OUT_W'({o_dropped, o_queued, o_handle, o_mask, o_ack, o_seq});

endmodule

`default_nettype wire

// File: sv/rdat_checker.sv
// ----------------------------------------------------------------------------
// rdat_checker
// Port-level checks of the ack tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rdat_checker
  import rdat_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic [ACTION_W-1:0] in_tuser,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [KIND_W-1:0]  out_tuser,
  input wire logic               out_tlast
);

  // a pending result item is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item withdrawn while stalled");

  // a real action keeps the input closed while it is worked
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != ACT_NONE) |=> !in_tready)
    else $error("input accepted while an item is at work");

  // only retransmit items leave tlast clear
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser != KIND_RETX)))
    else $error("tlast does not match result kind");

  // no result item starts while idle and the output was empty
  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && $past(in_tready) && !$past(out_tvalid) && $past(rst_n) |-> !out_tvalid)
    else $error("result item with no item at work");

endmodule

bind reliable_datagram_ack_tracker rdat_checker u_rdat_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
